// ===== src/hsh_pkg.sv =====
// hsh_pkg: shared constants and types for the hyperplane sign hash core.
// Used by hsh_lane, hsh_merge and hyperplane_sign_hash_core. No dependencies.
package hsh_pkg;

    localparam int MAX_PLANES = 16;
    localparam int DIMS       = 2;
    localparam int TERMS      = DIMS + 1;
    localparam int CODE_BITS  = 16;
    localparam int PLANES_CAP = (MAX_PLANES < CODE_BITS) ? MAX_PLANES : CODE_BITS;

    localparam int DATA_W  = 16;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int PLANE_W = 4;
    localparam int TERM_W  = 2;
    localparam int CNT_W   = 5;
    localparam int BIAS_SHIFT = DATA_W - 1;

    localparam logic [CNT_W-1:0] PLANE_COUNT_RESET = 5'd5;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_HASH = 1'b1;

    typedef logic signed [DATA_W-1:0] word_t;

    typedef struct packed {
        logic [TERMS-1:0] term_we;
        word_t            data;
    } wr_t;

endpackage

// ===== src/hsh_lane.sv =====
// hsh_lane: one hyperplane: coefficient and bias storage, multipliers, sign of the sum.
// Depends on hsh_pkg.
module hsh_lane
(
    input  logic          clk,
    input  hsh_pkg::wr_t  wr,
    input  hsh_pkg::word_t coord [hsh_pkg::DIMS],
    output logic          above
);

    hsh_pkg::word_t coef_reg [hsh_pkg::TERMS];
    logic signed [hsh_pkg::PROD_W-1:0] prod_reg [hsh_pkg::DIMS];
    hsh_pkg::word_t bias_reg;
    logic signed [hsh_pkg::SUM_W-1:0] sum;
    logic above_reg;

    always_ff @(posedge clk)
    begin
        for (int t = 0; t < hsh_pkg::TERMS; t++)
        begin
            if (wr.term_we[t])
            begin
                coef_reg[t] <= wr.data;
            end
        end
    end

    // stage 1: products and bias
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < hsh_pkg::DIMS; i++)
        begin
            prod_reg[i] <= coef_reg[i] * coord[i];
        end
        bias_reg <= coef_reg[hsh_pkg::DIMS];
    end

    always_comb
    begin
        sum = hsh_pkg::SUM_W'(bias_reg) <<< hsh_pkg::BIAS_SHIFT;
        for (int i = 0; i < hsh_pkg::DIMS; i++)
        begin
            sum = sum + hsh_pkg::SUM_W'(prod_reg[i]);
        end
    end

    // stage 2: strictly positive test
    always_ff @(posedge clk)
    begin
        above_reg <= !sum[hsh_pkg::SUM_W-1] && (sum != '0);
    end

    assign above = above_reg;

endmodule

// ===== src/hsh_merge.sv =====
// hsh_merge: packs the lane bits into the hash code, first plane most significant.
// Depends on hsh_pkg.
module hsh_merge
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          valid,
    input  logic [hsh_pkg::MAX_PLANES-1:0] above,
    input  logic [hsh_pkg::CNT_W-1:0]      plane_count,
    output logic [hsh_pkg::CODE_BITS-1:0]  hash_code,
    output logic                          done
);

    logic [hsh_pkg::CNT_W-1:0]     n_used;
    logic [hsh_pkg::CNT_W-1:0]     shift;
    logic [hsh_pkg::CODE_BITS-1:0] packed_bits;
    logic [hsh_pkg::CODE_BITS-1:0] hash_code_reg;
    logic [hsh_pkg::CODE_BITS-1:0] hash_code_next;
    logic                          done_reg;

    always_comb
    begin
        n_used = (plane_count > hsh_pkg::CNT_W'(hsh_pkg::PLANES_CAP))
               ? hsh_pkg::CNT_W'(hsh_pkg::PLANES_CAP) : plane_count;
        shift  = hsh_pkg::CNT_W'(hsh_pkg::CODE_BITS) - n_used;
        packed_bits = '0;
        for (int p = 0; p < hsh_pkg::PLANES_CAP; p++)
        begin
            packed_bits[hsh_pkg::CODE_BITS-1-p] = above[p];
        end
        hash_code_next = packed_bits >> shift;
    end

    always_ff @(posedge clk)
    begin
        hash_code_reg <= hash_code_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid;
        end
    end

    assign hash_code = hash_code_reg;
    assign done      = done_reg;

endmodule

// ===== src/hyperplane_sign_hash_core.sv =====
// hyperplane_sign_hash_core: random-hyperplane sign hash, one lane per plane.
// A hash word passes product, lane sign and merge registers before done and hash_code.
// Throughput: one word per cycle, load or hash; busy is always low. The rate is set
// by one pair of multipliers per plane lane, pipelined as products, sum, pack.
// Reset: pipeline valids cleared, plane_count returns to 5; coefficient table undefined.
// Depends on hsh_pkg, hsh_lane and hsh_merge.
module hyperplane_sign_hash_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          action,
    input  logic [hsh_pkg::PLANE_W-1:0]   plane_index,
    input  logic [hsh_pkg::TERM_W-1:0]    term_index,
    input  logic signed [hsh_pkg::DATA_W-1:0] coef_value,
    input  logic signed [hsh_pkg::DATA_W-1:0] coord_0,
    input  logic signed [hsh_pkg::DATA_W-1:0] coord_1,
    input  logic                          cfg_wr_en,
    input  logic [hsh_pkg::CNT_W-1:0]     cfg_wr_data,
    output logic [hsh_pkg::CODE_BITS-1:0] hash_code,
    output logic                          done
);

    logic                          accept;
    logic [hsh_pkg::CNT_W-1:0]     plane_count_reg;
    logic                          v1_reg;
    logic                          v2_reg;
    hsh_pkg::word_t                coord [hsh_pkg::DIMS];
    hsh_pkg::wr_t                  wr [hsh_pkg::MAX_PLANES];
    logic [hsh_pkg::MAX_PLANES-1:0] above;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign coord[0] = coord_0;
    assign coord[1] = coord_1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_count_reg <= hsh_pkg::PLANE_COUNT_RESET;
        end
        else if (cfg_wr_en)
        begin
            plane_count_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept && (action == hsh_pkg::ACT_HASH);
            v2_reg <= v1_reg;
        end
    end

    // load decode: a bias or coefficient word to one lane
    always_comb
    begin
        for (int p = 0; p < hsh_pkg::MAX_PLANES; p++)
        begin
            wr[p].data = coef_value;
            for (int t = 0; t < hsh_pkg::TERMS; t++)
            begin
                wr[p].term_we[t] = accept && (action == hsh_pkg::ACT_LOAD)
                                 && (plane_index == hsh_pkg::PLANE_W'(p))
                                 && (term_index == hsh_pkg::TERM_W'(t));
            end
        end
    end

    for (genvar g = 0; g < hsh_pkg::MAX_PLANES; g++)
    begin : g_lane
        hsh_lane u_lane
        (
            .clk   (clk),
            .wr    (wr[g]),
            .coord (coord),
            .above (above[g])
        );
    end

    hsh_merge u_merge
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .valid       (v2_reg),
        .above       (above),
        .plane_count (plane_count_reg),
        .hash_code   (hash_code),
        .done        (done)
    );

    a_done_from_hash: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(v2_reg))
        else $error("done without a hash word in the pipeline");

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (action == hsh_pkg::ACT_LOAD)) |=> !v1_reg)
        else $error("load word entered the hash pipeline");

    a_hash_flows: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |=> v2_reg ##1 done)
        else $error("hash word lost in the pipeline");

endmodule
